### hdl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types, byte codes and the rubout table for the line input editor.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int BUF_DEPTH      = 64;
   localparam int MAX_ESC_PARAMS = 7;

   localparam int IDX_W   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int SEQ_W   = (IDX_W > 3) ? IDX_W : 3;
   localparam int CAP_W   = 7;
   localparam int PARAM_W = 3;

   // result kinds
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // escape decoder modes
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_SEEN = 2'd1;
   localparam logic [1:0] ESC_CSI  = 2'd2;

   // byte codes
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PARAM_HI = 8'h3F;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_DEL      = 8'h7F;
   localparam logic [7:0] CH_CUR_LEFT = 8'h44;

   localparam logic [SEQ_W-1:0] RUB_LAST = SEQ_W'(6);

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

   // cursor left, space, cursor left
   function automatic logic [7:0] rub_byte(input logic [SEQ_W-1:0] idx);
      logic [7:0] b;
      case (idx[2:0])
         3'd0:    b = CH_ESC;
         3'd1:    b = CH_LBRACKET;
         3'd2:    b = CH_CUR_LEFT;
         3'd3:    b = CH_SPACE;
         3'd4:    b = CH_ESC;
         3'd5:    b = CH_LBRACKET;
         3'd6:    b = CH_CUR_LEFT;
         default: b = CH_SPACE;
      endcase
      return b;
   endfunction

endpackage

### hdl/tle_line_store.sv
// ----------------------------------------------------------------------------
// tle_line_store
// Line character memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tle_line_store (
   input  logic                     clock,
   input  tle_pkg::store_wr_type    wr,
   input  logic [tle_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [tle_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/terminal_line_input_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_input_editor
// Canonical terminal line input: echo, rubout, escape swallowing, line drain.
// ----------------------------------------------------------------------------
// Bytes from the terminal enter on the req_ channel (req_valid / req_stall);
// results leave on the rsp_ channel as kind, byte and last. A byte that makes
// no result (escape bytes, control bytes, DEL on an empty line) just returns
// the block to idle. csr_data sets the line capacity and is taken only while
// the sequencer is idle (csr_ready).
// One byte at a time: req_stall is high from acceptance until the sequencer
// has handed its last result to the output register. A printable byte passes
// through the decode and echo states, a swallowed byte through decode only,
// DEL through the rubout loop, and CR/LF through the line drain, in which each
// stored character costs a memory read state and an output state. The index
// counter and its compare are shared by the rubout and line drain loops. The
// output register lets the next byte be accepted while the last result of a
// byte waits for the receiver; a result held there by rsp_stall stalls the sequencer.
// Reset (synchronous) empties the line, clears the escape decoder and sets
// the capacity to 64; the line store itself is not cleared.
// ----------------------------------------------------------------------------
module terminal_line_input_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       rsp_stall,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_PUT      = 3'd2;
   localparam logic [2:0] S_RUB      = 3'd3;
   localparam logic [2:0] S_LINE     = 3'd4;
   localparam logic [2:0] S_LINE_OUT = 3'd5;

   localparam int IDX_W   = tle_pkg::IDX_W;
   localparam int SEQ_W   = tle_pkg::SEQ_W;
   localparam int CAP_W   = tle_pkg::CAP_W;
   localparam int PARAM_W = tle_pkg::PARAM_W;

   logic [2:0]         state_ff, state_in;
   logic [7:0]         byte_ff, byte_in;
   logic [1:0]         esc_ff, esc_in;
   logic [PARAM_W-1:0] param_ff, param_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [SEQ_W-1:0]   idx_ff, idx_in;
   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CAP_W-1:0]   limit_w;
   logic [IDX_W-1:0]   limit;
   logic [IDX_W-1:0]   cnt_clip;
   logic               slot_free;
   logic               load;
   logic [SEQ_W-1:0]   bound;
   logic               at_bound;
   logic [SEQ_W-1:0]   idx_next;
   logic [7:0]         rd_data;
   logic               printable;
   logic               param_byte;

   tle_pkg::store_wr_type wr;

   tle_line_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // capacity 0 acts as 1, above the store depth acts as the depth
   always_comb begin
      if (cap_ff == '0) begin
         limit_w = '0;
      end else if (cap_ff > CAP_W'(tle_pkg::BUF_DEPTH)) begin
         limit_w = CAP_W'(tle_pkg::BUF_DEPTH - 1);
      end else begin
         limit_w = cap_ff - CAP_W'(1);
      end
   end
   assign limit    = limit_w[IDX_W-1:0];
   assign cnt_clip = (cnt_ff > limit) ? limit : cnt_ff;

   // shared index unit for the rubout and line drain loops
   assign bound    = (state_ff == S_RUB) ? tle_pkg::RUB_LAST : SEQ_W'(cnt_ff);
   assign at_bound = (idx_ff == bound);
   assign idx_next = idx_ff + SEQ_W'(1);

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign printable  = (byte_ff >= tle_pkg::CH_SPACE) && (byte_ff <= tle_pkg::CH_TILDE);
   assign param_byte = (byte_ff >= tle_pkg::CH_SPACE) && (byte_ff <= tle_pkg::CH_PARAM_HI);

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      esc_in      = esc_ff;
      param_in    = param_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      load        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      wr.en       = 1'b0;
      wr.addr     = cnt_clip;
      wr.data     = byte_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in  = req_rx_byte;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cnt_in   = cnt_clip;
            state_in = S_IDLE;
            if (esc_ff == tle_pkg::ESC_SEEN) begin
               esc_in   = (byte_ff == tle_pkg::CH_LBRACKET) ? tle_pkg::ESC_CSI
                                                            : tle_pkg::ESC_NONE;
               param_in = '0;
            end else if (esc_ff == tle_pkg::ESC_CSI) begin
               if (param_ff < PARAM_W'(tle_pkg::MAX_ESC_PARAMS) && param_byte) begin
                  param_in = param_ff + PARAM_W'(1);
               end else begin
                  esc_in   = tle_pkg::ESC_NONE;
                  param_in = '0;
               end
            end else begin
               esc_in   = tle_pkg::ESC_NONE;
               param_in = '0;
               if (byte_ff == tle_pkg::CH_CR || byte_ff == tle_pkg::CH_LF) begin
                  idx_in   = '0;
                  state_in = S_LINE;
               end else if (byte_ff == tle_pkg::CH_ESC) begin
                  esc_in = tle_pkg::ESC_SEEN;
               end else if (printable) begin
                  state_in = S_PUT;
                  if (cnt_clip < limit) begin
                     wr.en  = 1'b1;
                     cnt_in = cnt_clip + IDX_W'(1);
                  end
               end else if (byte_ff == tle_pkg::CH_DEL) begin
                  if (cnt_clip != '0) begin
                     cnt_in   = cnt_clip - IDX_W'(1);
                     idx_in   = '0;
                     state_in = S_RUB;
                  end
               end
            end
         end
         S_PUT: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_kind_in = tle_pkg::KIND_ECHO;
               rsp_byte_in = byte_ff;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_RUB: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_kind_in = tle_pkg::KIND_ECHO;
               rsp_byte_in = tle_pkg::rub_byte(idx_ff);
               rsp_last_in = at_bound;
               idx_in      = idx_next;
               if (at_bound) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LINE: begin
            // memory read of idx_ff lands in rd_data on the way to S_LINE_OUT
            if (!at_bound) begin
               state_in = S_LINE_OUT;
            end else if (slot_free) begin
               load        = 1'b1;
               rsp_kind_in = tle_pkg::KIND_END;
               rsp_byte_in = '0;
               rsp_last_in = 1'b1;
               cnt_in      = '0;
               state_in    = S_IDLE;
            end
         end
         S_LINE_OUT: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_kind_in = tle_pkg::KIND_CHAR;
               rsp_byte_in = rd_data;
               rsp_last_in = 1'b0;
               idx_in      = idx_next;
               state_in    = S_LINE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         esc_ff       <= tle_pkg::ESC_NONE;
         param_ff     <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         cap_ff       <= CAP_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         param_ff     <= param_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign csr_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // line characters are never the closing result of a transaction
   a_char_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == tle_pkg::KIND_CHAR |-> !rsp_last)
      else $error("line character flagged as last");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == tle_pkg::KIND_END |-> rsp_out_byte == 8'h00 && rsp_last)
      else $error("line end with nonzero byte or not last");

   a_cnt_in_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECODE |=> cnt_ff <= limit)
      else $error("character count above line limit");

   a_line_out_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINE_OUT |-> $past(state_ff) == S_LINE || $past(state_ff) == S_LINE_OUT)
      else $error("line output without a preceding store read");

endmodule

### verif/editor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// editor_checker
// Watches the byte, result and capacity channels of the line input editor.
// It keeps its own copy of the line, the escape decoder and the capacity.
// It works out the results of each accepted byte and compares every result
// transaction with the oldest one still waiting.
// ----------------------------------------------------------------------------
module editor_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       req_stall,
   input  logic       rsp_valid,
   input  logic [1:0] rsp_out_kind,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   input  logic       rsp_stall,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_data,
   output int         fail_count,
   output int         outstanding
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } line_out_type;

   line_out_type  awaited_out [$];
   line_out_type  oldest;

   logic [6:0] capacity;
   logic [1:0] esc_mode;
   logic [2:0] param_cnt;
   logic [6:0] char_cnt;
   logic [7:0] line_mem [0:tle_pkg::BUF_DEPTH-1];

   task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic last);
      line_out_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      awaited_out.push_back(r);
   endtask

   task automatic edit_line(input logic [7:0] c);
      int         k;
      logic [6:0] max_chars;
      logic [7:0] rub;
      if (capacity == 7'd0)
         max_chars = 7'd0;
      else if (capacity > tle_pkg::BUF_DEPTH)
         max_chars = 7'(tle_pkg::BUF_DEPTH - 1);
      else
         max_chars = capacity - 7'd1;
      // a capacity lowered mid-line cuts the line before this byte
      if (char_cnt > max_chars)
         char_cnt = max_chars;

      case (esc_mode)
         tle_pkg::ESC_SEEN: begin
            esc_mode  = (c == tle_pkg::CH_LBRACKET) ? tle_pkg::ESC_CSI : tle_pkg::ESC_NONE;
            param_cnt = 3'd0;
         end
         tle_pkg::ESC_CSI: begin
            if (param_cnt < tle_pkg::MAX_ESC_PARAMS && c >= tle_pkg::CH_SPACE &&
                c <= tle_pkg::CH_PARAM_HI) begin
               param_cnt = param_cnt + 3'd1;
            end else begin
               esc_mode  = tle_pkg::ESC_NONE;
               param_cnt = 3'd0;
            end
         end
         default: begin
            esc_mode  = tle_pkg::ESC_NONE;
            param_cnt = 3'd0;
            if (c == tle_pkg::CH_CR || c == tle_pkg::CH_LF) begin
               for (k = 0; k < char_cnt; k++)
                  queue_result(tle_pkg::KIND_CHAR, line_mem[k], 1'b0);
               queue_result(tle_pkg::KIND_END, 8'h00, 1'b1);
               char_cnt = 7'd0;
            end else if (c == tle_pkg::CH_ESC) begin
               esc_mode = tle_pkg::ESC_SEEN;
            end else if (c >= tle_pkg::CH_SPACE && c <= tle_pkg::CH_TILDE) begin
               queue_result(tle_pkg::KIND_ECHO, c, 1'b1);
               // full line: echoed, not kept
               if (char_cnt < max_chars) begin
                  line_mem[char_cnt[5:0]] = c;
                  char_cnt = char_cnt + 7'd1;
               end
            end else if (c == tle_pkg::CH_DEL && char_cnt != 7'd0) begin
               char_cnt = char_cnt - 7'd1;
               // cursor left, blank, cursor left
               for (k = 0; k < 7; k++) begin
                  case (k % 4)
                     0:       rub = tle_pkg::CH_ESC;
                     1:       rub = tle_pkg::CH_LBRACKET;
                     2:       rub = tle_pkg::CH_CUR_LEFT;
                     default: rub = tle_pkg::CH_SPACE;
                  endcase
                  queue_result(tle_pkg::KIND_ECHO, rub, k == 6);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capacity  = 7'd64;
         esc_mode  = tle_pkg::ESC_NONE;
         param_cnt = 3'd0;
         char_cnt  = 7'd0;
         awaited_out.delete();
      end else begin
         if (csr_valid && csr_ready)
            capacity = csr_data;

         if (rsp_valid && !rsp_stall) begin
            if (awaited_out.size() == 0) begin
               $error("rsp: transaction with nothing expected, kind %0d byte %02h last %0d",
                      rsp_out_kind, rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               oldest = awaited_out.pop_front();
               if (rsp_out_kind !== oldest.kind) begin
                  $error("rsp_out_kind: expected %0d, got %0d", oldest.kind, rsp_out_kind);
                  fail_count++;
               end
               if (rsp_out_byte !== oldest.data) begin
                  $error("rsp_out_byte: expected %02h, got %02h", oldest.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("rsp_last: expected %0d, got %0d", oldest.last, rsp_last);
                  fail_count++;
               end
            end
         end

         if (req_valid && !req_stall)
            edit_line(req_rx_byte);
      end
      outstanding = awaited_out.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the terminal line input editor.
// Directed bytes first (rubout, empty lines, ignored bytes, escape swallowing,
// capacity cut mid-line), then random typed lines with edits and escape
// sequences under several capacities and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_LIMIT     = 3000;
   localparam int ITEMS_PER_PHASE = 50;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_stall;
   logic       rsp_valid;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_stall   = 1'b0;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data    = 7'd0;

   int fail_count;
   int outstanding;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int bytes_sent  = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   terminal_line_input_editor dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_stall    (rsp_stall),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   editor_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_stall    (rsp_stall),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so a following byte sent without a gap keeps valid up
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_line_drained();
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] cap);
      wait_line_drained();
      // a swallowed byte may still be in flight
      repeat (8) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_escape();
      int n;
      int k;
      send_byte(tle_pkg::CH_ESC);
      if ($urandom_range(3) == 0) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(tle_pkg::CH_LBRACKET);
         n = $urandom_range(9);
         for (k = 0; k < n; k++)
            send_byte(8'($urandom_range(63, 32)));
         send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic send_random_line();
      int len;
      int k;
      int pick;
      len = ($urandom_range(19) == 0) ? $urandom_range(70, 55) : $urandom_range(12);
      for (k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 68)
            send_byte(8'($urandom_range(126, 32)));
         else if (pick < 80)
            send_byte(tle_pkg::CH_DEL);
         else if (pick < 88)
            send_escape();
         else if (pick < 95)
            send_byte(8'($urandom_range(255)));
         else
            send_byte(8'($urandom_range(31)));
      end
      send_byte($urandom_range(1) ? tle_pkg::CH_CR : tle_pkg::CH_LF);
   endtask

   initial begin
      int         p;
      int         target;
      logic [6:0] cap;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // printable extremes, rubout down to an empty line and once more
      send_byte(tle_pkg::CH_SPACE);
      send_byte(tle_pkg::CH_TILDE);
      send_byte(tle_pkg::CH_DEL);
      send_byte(tle_pkg::CH_DEL);
      send_byte(tle_pkg::CH_DEL);
      // one-character line, then an empty line
      send_byte(8'h78);
      send_byte(tle_pkg::CH_CR);
      send_byte(tle_pkg::CH_LF);
      // ignored bytes
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h09);
      send_byte(8'h00);
      // escape swallows a line end, then another escape
      send_byte(tle_pkg::CH_ESC);
      send_byte(tle_pkg::CH_CR);
      send_byte(tle_pkg::CH_ESC);
      send_byte(tle_pkg::CH_ESC);
      // csi with parameters, final byte is a line end
      send_byte(tle_pkg::CH_ESC);
      send_byte(tle_pkg::CH_LBRACKET);
      send_byte(8'h3F);
      send_byte(tle_pkg::CH_SPACE);
      send_byte(tle_pkg::CH_LF);
      // capacity lowered under a partial line
      send_byte(8'h61);
      send_byte(8'h62);
      send_byte(8'h63);
      write_capacity(7'd2);
      send_byte(tle_pkg::CH_CR);

      target = bytes_sent;
      for (p = 0; p < 8; p++) begin
         case (p)
            0:       cap = 7'd1;
            1:       cap = 7'd64;
            2:       cap = 7'd2;
            3:       cap = 7'd0;
            4:       cap = 7'd127;
            5:       cap = 7'd5;
            6:       cap = 7'd65;
            default: cap = 7'($urandom_range(63, 3));
         endcase
         write_capacity(cap);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         target += ITEMS_PER_PHASE;
         while (bytes_sent < target) begin
            send_random_line();
            // occasionally hold off until the editor has emptied its output
            if ($urandom_range(9) == 0)
               wait_line_drained();
         end
      end

      wait_line_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

### sim.f
hdl/tle_pkg.sv
hdl/tle_line_store.sv
hdl/terminal_line_input_editor.sv
verif/editor_checker.sv
verif/tb.sv
